// File: rtl/core/rmq_pkg.sv
package rmq_pkg;

   localparam int FRAC_BITS_DEF = 14;
   localparam int ELEM_W        = 16;
   localparam int NUM_W         = 17;

   typedef enum logic [1:0] {
      ROOT_X,
      ROOT_Y,
      ROOT_Z,
      ROOT_W
   } root_type;

endpackage

// File: rtl/core/rmq_isqrt.sv
module rmq_isqrt #(
   parameter int IN_W   = 32,
   parameter int SIDE_W = 1,
   localparam int RT_W  = (IN_W + 1) / 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [IN_W-1:0]   in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [RT_W-1:0]   out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int PAD_W = 2 * RT_W;
   localparam int REM_W = RT_W + 2;

   logic              valid_ff [0:RT_W];
   logic [RT_W-1:0]   root_ff  [0:RT_W];
   logic [SIDE_W-1:0] side_ff  [0:RT_W];
   logic [PAD_W-1:0]  rad_ff   [0:RT_W-1];
   logic [REM_W-1:0]  rem_ff   [0:RT_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      rad_ff[0]  <= PAD_W'(in_rad);
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      side_ff[0] <= in_side;
   end

   for (genvar t = 0; t < RT_W; t++) begin : g_step
      logic [REM_W+1:0] cur;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] diff;
      logic             take;

      assign cur   = {rem_ff[t], rad_ff[t][PAD_W-1 -: 2]};
      assign trial = (REM_W + 2)'({root_ff[t], 2'b01});
      assign take  = (cur >= trial);
      assign diff  = cur - trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[t+1] <= 1'b0;
         end else begin
            valid_ff[t+1] <= valid_ff[t];
         end
         root_ff[t+1] <= {root_ff[t][RT_W-2:0], take};
         side_ff[t+1] <= side_ff[t];
      end

      if (t < RT_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rad_ff[t+1] <= rad_ff[t] << 2;
            rem_ff[t+1] <= take ? REM_W'(diff) : REM_W'(cur);
         end
      end
   end

   assign out_valid = valid_ff[RT_W];
   assign out_root  = root_ff[RT_W];
   assign out_side  = side_ff[RT_W];

endmodule

// File: rtl/core/rmq_div.sv
module rmq_div #(
   parameter int DVD_W  = 32,
   parameter int DVS_W  = 17,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DVD_W-1:0]  in_dividend,
   input  logic [DVS_W-1:0]  in_divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [DVD_W-1:0]  out_quot,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [0:DVD_W];
   logic [DVD_W-1:0]  dvd_ff   [0:DVD_W];
   logic [SIDE_W-1:0] side_ff  [0:DVD_W];
   logic [DVS_W-1:0]  rem_ff   [0:DVD_W-1];
   logic [DVS_W-1:0]  dvs_ff   [0:DVD_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      dvd_ff[0]  <= in_dividend;
      dvs_ff[0]  <= in_divisor;
      rem_ff[0]  <= '0;
      side_ff[0] <= in_side;
   end

   for (genvar t = 0; t < DVD_W; t++) begin : g_step
      logic [DVS_W:0] cur;
      logic [DVS_W:0] diff;
      logic           take;

      assign cur  = {rem_ff[t], dvd_ff[t][DVD_W-1]};
      assign take = (cur >= {1'b0, dvs_ff[t]});
      assign diff = cur - {1'b0, dvs_ff[t]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[t+1] <= 1'b0;
         end else begin
            valid_ff[t+1] <= valid_ff[t];
         end
         dvd_ff[t+1]  <= {dvd_ff[t][DVD_W-2:0], take};
         side_ff[t+1] <= side_ff[t];
      end

      if (t < DVD_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[t+1] <= take ? DVS_W'(diff) : DVS_W'(cur);
            dvs_ff[t+1] <= dvs_ff[t];
         end
      end
   end

   assign out_valid = valid_ff[DVD_W];
   assign out_quot  = dvd_ff[DVD_W];
   assign out_side  = side_ff[DVD_W];

endmodule

// File: rtl/core/rotation_matrix_to_quaternion_unit.sv
// From start to rsp_valid: a root step per root bit, a divider step per quotient
// bit, then an output register; at FRAC_BITS = 14, 16 root and 32 divider steps.
// Throughput: one transaction per cycle; busy is low except during reset.
// The receiver cannot stall; every result shows for one cycle with rsp_valid.
// Reset (synchronous) clears all valid bits; transactions in flight are dropped.
module rotation_matrix_to_quaternion_unit #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_m00,
   input  logic signed [15:0] req_m01,
   input  logic signed [15:0] req_m02,
   input  logic signed [15:0] req_m10,
   input  logic signed [15:0] req_m11,
   input  logic signed [15:0] req_m12,
   input  logic signed [15:0] req_m20,
   input  logic signed [15:0] req_m21,
   input  logic signed [15:0] req_m22,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z,
   output logic signed [15:0] rsp_quat_w,
   output logic               rsp_degenerate
);

   localparam int NUM_W  = rmq_pkg::NUM_W;
   localparam int RAD_W  = ((FRAC_BITS > NUM_W) ? FRAC_BITS : NUM_W) + 2;
   localparam int SQI_W  = RAD_W - 1 + FRAC_BITS;
   localparam int SQ_W   = (SQI_W + 1) / 2;
   localparam int DVD_W  = NUM_W + FRAC_BITS + 1;
   localparam int DVS_W  = SQ_W + 1;
   localparam int LIM    = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
   localparam int LAT    = SQ_W + DVD_W + 3;
   localparam logic [15:0] LIM16 = 16'(LIM);
   localparam logic signed [RAD_W-1:0] ONE = RAD_W'(64'sd1 <<< FRAC_BITS);

   typedef struct packed {
      logic [NUM_W-1:0]  mag0;
      logic [NUM_W-1:0]  mag1;
      logic [NUM_W-1:0]  mag2;
      logic              sgn0;
      logic              sgn1;
      logic              sgn2;
      rmq_pkg::root_type root;
      logic              degen;
   } sq_side_type;

   typedef struct packed {
      logic              sgn;
      rmq_pkg::root_type root;
      logic              degen;
      logic [15:0]       rootc;
   } lane_side_type;

   localparam int SQS_W = $bits(sq_side_type);
   localparam int L0S_W = $bits(lane_side_type);

   logic                     accept;
   logic signed [RAD_W-1:0]  e00, e11, e22, trace, rad;
   logic signed [NUM_W-1:0]  n0, n1, n2;
   logic signed [NUM_W-1:0]  d21_12, d02_20, d10_01, s10_01, s20_02, s21_12;
   rmq_pkg::root_type        root;
   logic                     degen;
   sq_side_type              sq_in, sq_out;
   logic                     sq_valid;
   logic [SQ_W-1:0]          sq_root;
   logic [SQ_W:0]            half;
   lane_side_type            l0_in, l0_out;
   logic [DVS_W-1:0]         divisor;
   logic [DVD_W-1:0]         dvd0, dvd1, dvd2;
   logic [DVD_W-1:0]         quot0, quot1, quot2;
   logic                     dv_valid0, dv_valid1, dv_valid2;
   logic                     sgn1_out, sgn2_out;
   logic signed [15:0]       v0, v1, v2, vr;
   logic signed [15:0]       qx_in, qy_in, qz_in, qw_in;
   logic                     rsp_valid_ff;
   logic signed [15:0]       qx_ff, qy_ff, qz_ff, qw_ff;
   logic                     degen_ff;

   function automatic logic signed [15:0] sat_lane(input logic [DVD_W-1:0] q,
                                                   input logic sgn);
      logic [15:0] mag;
      mag = (q > DVD_W'(LIM)) ? LIM16 : q[15:0];
      return sgn ? -signed'(mag) : signed'(mag);
   endfunction

   assign busy   = reset;
   assign accept = start && !busy;

   assign e00   = RAD_W'(req_m00);
   assign e11   = RAD_W'(req_m11);
   assign e22   = RAD_W'(req_m22);
   assign trace = e00 + e11 + e22;

   assign d21_12 = NUM_W'(req_m21) - NUM_W'(req_m12);
   assign d02_20 = NUM_W'(req_m02) - NUM_W'(req_m20);
   assign d10_01 = NUM_W'(req_m10) - NUM_W'(req_m01);
   assign s10_01 = NUM_W'(req_m10) + NUM_W'(req_m01);
   assign s20_02 = NUM_W'(req_m20) + NUM_W'(req_m02);
   assign s21_12 = NUM_W'(req_m21) + NUM_W'(req_m12);

   always_comb begin
      root  = rmq_pkg::ROOT_W;
      rad   = trace + ONE;
      n0    = d21_12;
      n1    = d02_20;
      n2    = d10_01;
      degen = 1'b0;
      if (!(trace > 0)) begin
         if (e11 > e00) begin
            root = (e22 > e11) ? rmq_pkg::ROOT_Z : rmq_pkg::ROOT_Y;
         end else begin
            root = (e22 > e00) ? rmq_pkg::ROOT_Z : rmq_pkg::ROOT_X;
         end
         unique case (root)
            rmq_pkg::ROOT_X: begin
               rad = e00 - e11 - e22 + ONE;
               n0  = s10_01;
               n1  = s20_02;
               n2  = d21_12;
            end
            rmq_pkg::ROOT_Y: begin
               rad = e11 - e22 - e00 + ONE;
               n0  = s10_01;
               n1  = s21_12;
               n2  = d02_20;
            end
            rmq_pkg::ROOT_Z: begin
               rad = e22 - e00 - e11 + ONE;
               n0  = s20_02;
               n1  = s21_12;
               n2  = d10_01;
            end
            rmq_pkg::ROOT_W: begin
               rad = trace + ONE;
            end
         endcase
         if (rad <= 0) begin
            rad   = RAD_W'(1);
            degen = 1'b1;
         end
      end
   end

   always_comb begin
      sq_in.sgn0  = n0[NUM_W-1];
      sq_in.sgn1  = n1[NUM_W-1];
      sq_in.sgn2  = n2[NUM_W-1];
      sq_in.mag0  = n0[NUM_W-1] ? NUM_W'(-n0) : NUM_W'(n0);
      sq_in.mag1  = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
      sq_in.mag2  = n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
      sq_in.root  = root;
      sq_in.degen = degen;
   end

   rmq_isqrt #(
      .IN_W   (SQI_W),
      .SIDE_W (SQS_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_rad    ({rad[RAD_W-2:0], {FRAC_BITS{1'b0}}}),
      .in_side   (sq_in),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_out)
   );

   assign half    = ({1'b0, sq_root} + (SQ_W + 1)'(1)) >> 1;
   assign divisor = {sq_root, 1'b0};
   assign dvd0    = DVD_W'({sq_out.mag0, {FRAC_BITS{1'b0}}}) + DVD_W'(sq_root);
   assign dvd1    = DVD_W'({sq_out.mag1, {FRAC_BITS{1'b0}}}) + DVD_W'(sq_root);
   assign dvd2    = DVD_W'({sq_out.mag2, {FRAC_BITS{1'b0}}}) + DVD_W'(sq_root);

   always_comb begin
      l0_in.sgn   = sq_out.sgn0;
      l0_in.root  = sq_out.root;
      l0_in.degen = sq_out.degen;
      l0_in.rootc = (half > (SQ_W + 1)'(LIM)) ? LIM16 : 16'(half);
   end

   rmq_div #(
      .DVD_W  (DVD_W),
      .DVS_W  (DVS_W),
      .SIDE_W (L0S_W)
   ) u_div0 (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (sq_valid),
      .in_dividend (dvd0),
      .in_divisor  (divisor),
      .in_side     (l0_in),
      .out_valid   (dv_valid0),
      .out_quot    (quot0),
      .out_side    (l0_out)
   );

   rmq_div #(
      .DVD_W  (DVD_W),
      .DVS_W  (DVS_W),
      .SIDE_W (1)
   ) u_div1 (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (sq_valid),
      .in_dividend (dvd1),
      .in_divisor  (divisor),
      .in_side     (sq_out.sgn1),
      .out_valid   (dv_valid1),
      .out_quot    (quot1),
      .out_side    (sgn1_out)
   );

   rmq_div #(
      .DVD_W  (DVD_W),
      .DVS_W  (DVS_W),
      .SIDE_W (1)
   ) u_div2 (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (sq_valid),
      .in_dividend (dvd2),
      .in_divisor  (divisor),
      .in_side     (sq_out.sgn2),
      .out_valid   (dv_valid2),
      .out_quot    (quot2),
      .out_side    (sgn2_out)
   );

   assign v0 = sat_lane(quot0, l0_out.sgn);
   assign v1 = sat_lane(quot1, sgn1_out);
   assign v2 = sat_lane(quot2, sgn2_out);
   assign vr = signed'(l0_out.rootc);

   always_comb begin
      qx_in = v0;
      qy_in = v1;
      qz_in = v2;
      qw_in = vr;
      unique case (l0_out.root)
         rmq_pkg::ROOT_X: begin
            qx_in = vr;
            qy_in = v0;
            qz_in = v1;
            qw_in = v2;
         end
         rmq_pkg::ROOT_Y: begin
            qx_in = v0;
            qy_in = vr;
            qz_in = v1;
            qw_in = v2;
         end
         rmq_pkg::ROOT_Z: begin
            qx_in = v0;
            qy_in = v1;
            qz_in = vr;
            qw_in = v2;
         end
         rmq_pkg::ROOT_W: begin
            qx_in = v0;
            qy_in = v1;
            qz_in = v2;
            qw_in = vr;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid0;
      end
      qx_ff    <= qx_in;
      qy_ff    <= qy_in;
      qz_ff    <= qz_in;
      qw_ff    <= qw_in;
      degen_ff <= l0_out.degen;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_quat_x     = qx_ff;
   assign rsp_quat_y     = qy_ff;
   assign rsp_quat_z     = qz_ff;
   assign rsp_quat_w     = qw_ff;
   assign rsp_degenerate = degen_ff;

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (dv_valid0 == dv_valid1) && (dv_valid0 == dv_valid2))
      else $error("divider lanes out of step");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("result without matching transaction");

   a_degen_branch: assert property (@(posedge clock) disable iff (reset)
      dv_valid0 && l0_out.degen |-> l0_out.root != rmq_pkg::ROOT_W)
      else $error("degenerate flag in trace branch");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_quat_x <= LIM) && (rsp_quat_x >= -LIM)
                 && (rsp_quat_w <= LIM) && (rsp_quat_w >= -LIM))
      else $error("component out of range");

endmodule
